>>> rtl/postfix_expression_evaluator_defines.svh
// Assertion macros shared by the postfix expression evaluator RTL.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_DEFINES_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PEE_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PEE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/pee_pkg.sv
// Shared types, character codes and command/status structs of the postfix evaluator.
package pee_pkg;

    localparam int STACK_DEPTH_DEF = 16;

    // Expression characters
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_CARET = 8'h5E;

    // Last step-counter values of the divider and power loops
    localparam logic [5:0] DIV_LAST = 6'd31;  // one quotient bit per cycle
    localparam logic [5:0] POW_LAST = 6'd61;  // multiply and square per exponent bit

    typedef enum logic [2:0] {
        CLS_DIGIT,
        CLS_SEMI,
        CLS_ADD,
        CLS_SUB,
        CLS_MUL,
        CLS_DIV,
        CLS_POW,
        CLS_OTHER
    } char_cls_t;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_UNDER = 3'd1,
        ST_OVER  = 3'd2,
        ST_DIVZ  = 3'd3,
        ST_EMPTY = 3'd4
    } status_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;     // latch the incoming character
        logic acc_digit;  // fold a digit into the number accumulator
        logic push_acc;   // push the pending number, if any
        logic pop;        // read two operands, drop them from the stack
        logic underflow;  // too few operands: empty the stack, flag it
        logic oper;       // evaluate or start the operator
        logic flag_divz;  // divide by zero
        logic div_step;
        logic div_fix;
        logic pow_step;
        logic push_res;
        logic rd_top;     // read the top of stack for the result
        logic out_load;   // load the result register, clear the expression
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        char_cls_t cls;
        logic      last;
        logic      lt2;
        logic      a_zero;
        logic      b_zero;
        logic      b_neg;
        logic      div_done;
        logic      pow_done;
        logic      out_free;
    } stat_t;

    function automatic char_cls_t char_class(input logic [7:0] c);
        char_cls_t r;
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            r = CLS_DIGIT;
        end
        else
        begin
            case (c)
                CH_SEMI:  r = CLS_SEMI;
                CH_PLUS:  r = CLS_ADD;
                CH_MINUS: r = CLS_SUB;
                CH_STAR:  r = CLS_MUL;
                CH_SLASH: r = CLS_DIV;
                CH_CARET: r = CLS_POW;
                default:  r = CLS_OTHER;
            endcase
        end
        return r;
    endfunction

endpackage

>>> rtl/pee_datapath.sv
// Datapath: operand stack, number accumulator, ALU, divider, power unit, result register.
module pee_datapath #(
    parameter int STACK_DEPTH = pee_pkg::STACK_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [7:0]      ch,
    input  logic            last,
    input  pee_pkg::cmd_t   cmd,
    output pee_pkg::stat_t  stat,
    output logic            result_valid,
    input  logic            result_stall,
    output logic [31:0]     value,
    output logic [2:0]      status
);
    import pee_pkg::*;

    localparam int SP_W  = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = $clog2(STACK_DEPTH);

    logic [31:0] mem [STACK_DEPTH];

    logic [7:0]      ch_reg;
    logic            last_reg;
    logic [SP_W-1:0] sp_reg, sp_next;
    logic [31:0]     acc_reg, acc_next;
    logic            innum_reg, innum_next;
    status_t         err_reg, err_next;
    logic [31:0]     rda_reg, rdb_reg;
    logic [31:0]     res_reg, res_next;
    logic [31:0]     sq_reg, sq_next;
    logic [30:0]     ex_reg, ex_next;
    logic [31:0]     rem_reg, rem_next;
    logic [31:0]     quo_reg, quo_next;
    logic [31:0]     dvs_reg, dvs_next;
    logic            neg_reg, neg_next;
    logic [5:0]      cnt_reg, cnt_next;
    logic [31:0]     value_reg, value_next;
    status_t         status_reg, status_next;
    logic            rvalid_reg, rvalid_next;

    char_cls_t       cls;
    logic [SP_W-1:0] sp_m1, sp_m2;
    logic            full;
    logic            push_en;
    logic [31:0]     push_data;
    logic [3:0]      digit;
    logic [31:0]     mul_x, mul_y, mul_p;
    logic [32:0]     rem_sh, rem_diff;
    logic            out_free;
    status_t         fin_status;

    assign cls      = char_class(ch_reg);
    assign sp_m1    = sp_reg - SP_W'(1);
    assign sp_m2    = sp_reg - SP_W'(2);
    assign full     = (sp_reg == SP_W'(STACK_DEPTH));
    assign digit    = 4'(ch_reg - CH_ZERO);
    assign out_free = !rvalid_reg || !result_stall;

    // Push source: pending number or operator result
    assign push_en   = (cmd.push_acc && innum_reg) || cmd.push_res;
    assign push_data = cmd.push_res ? res_reg : acc_reg;

    // Shared 32x32 multiplier, low word only
    always_comb
    begin
        if (cmd.pow_step)
        begin
            mul_x = cnt_reg[0] ? sq_reg : res_reg;
            mul_y = sq_reg;
        end
        else
        begin
            mul_x = rda_reg;
            mul_y = rdb_reg;
        end
    end
    assign mul_p = mul_x * mul_y;

    // Restoring divider step
    assign rem_sh   = {rem_reg, quo_reg[31]};
    assign rem_diff = rem_sh - {1'b0, dvs_reg};

    // Final status of an expression
    always_comb
    begin
        if (err_reg != ST_OK)
            fin_status = err_reg;
        else if (sp_reg == '0)
            fin_status = ST_EMPTY;
        else
            fin_status = ST_OK;
    end

    // Next-state logic
    always_comb
    begin
        sp_next     = sp_reg;
        acc_next    = acc_reg;
        innum_next  = innum_reg;
        err_next    = err_reg;
        res_next    = res_reg;
        sq_next     = sq_reg;
        ex_next     = ex_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        dvs_next    = dvs_reg;
        neg_next    = neg_reg;
        cnt_next    = cnt_reg;
        value_next  = value_reg;
        status_next = status_reg;
        rvalid_next = rvalid_reg;

        if (rvalid_reg && !result_stall)
            rvalid_next = 1'b0;

        if (cmd.acc_digit)
        begin
            acc_next   = (acc_reg << 3) + (acc_reg << 1) + 32'(digit);
            innum_next = 1'b1;
        end

        if (cmd.push_acc)
        begin
            acc_next   = '0;
            innum_next = 1'b0;
        end

        // Push with overflow check
        if (push_en)
        begin
            if (full)
            begin
                if (err_reg == ST_OK)
                    err_next = ST_OVER;
            end
            else
            begin
                sp_next = sp_reg + SP_W'(1);
            end
        end

        if (cmd.pop)
            sp_next = sp_m2;

        if (cmd.underflow)
        begin
            sp_next = '0;
            if (err_reg == ST_OK)
                err_next = ST_UNDER;
        end

        if (cmd.flag_divz && err_reg == ST_OK)
            err_next = ST_DIVZ;

        // Operator evaluation or unit start
        if (cmd.oper)
        begin
            case (cls)
                CLS_ADD: res_next = rda_reg + rdb_reg;
                CLS_SUB: res_next = rda_reg - rdb_reg;
                CLS_MUL: res_next = mul_p;
                CLS_DIV:
                begin
                    rem_next = '0;
                    quo_next = rda_reg[31] ? (32'd0 - rda_reg) : rda_reg;
                    dvs_next = rdb_reg[31] ? (32'd0 - rdb_reg) : rdb_reg;
                    neg_next = rda_reg[31] ^ rdb_reg[31];
                    cnt_next = '0;
                end
                CLS_POW:
                begin
                    if (rdb_reg[31])
                    begin
                        // negative exponent: only unit-magnitude bases survive
                        if (rda_reg == 32'd1)
                            res_next = 32'd1;
                        else if (rda_reg == '1)
                            res_next = rdb_reg[0] ? '1 : 32'd1;
                        else
                            res_next = '0;
                    end
                    else
                    begin
                        res_next = 32'd1;
                        sq_next  = rda_reg;
                        ex_next  = rdb_reg[30:0];
                        cnt_next = '0;
                    end
                end
                default: ;
            endcase
        end

        if (cmd.div_step)
        begin
            if (!rem_diff[32])
                rem_next = rem_diff[31:0];
            else
                rem_next = rem_sh[31:0];
            quo_next = {quo_reg[30:0], !rem_diff[32]};
            cnt_next = cnt_reg + 6'd1;
        end

        if (cmd.div_fix)
            res_next = neg_reg ? (32'd0 - quo_reg) : quo_reg;

        // Square and multiply: multiply on even steps, square and shift the exponent on odd steps
        if (cmd.pow_step)
        begin
            if (!cnt_reg[0])
            begin
                if (ex_reg[0])
                    res_next = mul_p;
            end
            else
            begin
                sq_next = mul_p;
                ex_next = {1'b0, ex_reg[30:1]};
            end
            cnt_next = cnt_reg + 6'd1;
        end

        // Result transfer and expression clear
        if (cmd.out_load)
        begin
            status_next = fin_status;
            value_next  = (fin_status == ST_OK) ? rdb_reg : '0;
            rvalid_next = 1'b1;
            sp_next     = '0;
            acc_next    = '0;
            innum_next  = 1'b0;
            err_next    = ST_OK;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg     <= '0;
            acc_reg    <= '0;
            innum_reg  <= 1'b0;
            err_reg    <= ST_OK;
            cnt_reg    <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            sp_reg     <= sp_next;
            acc_reg    <= acc_next;
            innum_reg  <= innum_next;
            err_reg    <= err_next;
            cnt_reg    <= cnt_next;
            rvalid_reg <= rvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            ch_reg   <= ch;
            last_reg <= last;
        end
        res_reg    <= res_next;
        sq_reg     <= sq_next;
        ex_reg     <= ex_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        dvs_reg    <= dvs_next;
        neg_reg    <= neg_next;
        value_reg  <= value_next;
        status_reg <= status_next;
    end

    // Operand stack: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (push_en && !full)
            mem[sp_reg[IDX_W-1:0]] <= push_data;
        if (cmd.pop || cmd.rd_top)
        begin
            rdb_reg <= mem[sp_m1[IDX_W-1:0]];
            rda_reg <= mem[sp_m2[IDX_W-1:0]];
        end
    end

    assign stat.cls      = cls;
    assign stat.last     = last_reg;
    assign stat.lt2      = (sp_reg < SP_W'(2));
    assign stat.a_zero   = (rda_reg == '0);
    assign stat.b_zero   = (rdb_reg == '0);
    assign stat.b_neg    = rdb_reg[31];
    assign stat.div_done = (cnt_reg == DIV_LAST);
    assign stat.pow_done = (cnt_reg == POW_LAST);
    assign stat.out_free = out_free;

    assign result_valid = rvalid_reg;
    assign value        = value_reg;
    assign status       = status_reg;

endmodule

>>> rtl/pee_ctrl.sv
// Controller: sequences each character through the datapath.
module pee_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_stall,
    input  pee_pkg::stat_t stat,
    output pee_pkg::cmd_t  cmd
);
    import pee_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE    = 11'b000_0000_0001,
        S_DECODE  = 11'b000_0000_0010,
        S_POP     = 11'b000_0000_0100,
        S_OPER    = 11'b000_0000_1000,
        S_DIV     = 11'b000_0001_0000,
        S_DIVFIX  = 11'b000_0010_0000,
        S_POW     = 11'b000_0100_0000,
        S_PUSHRES = 11'b000_1000_0000,
        S_FLUSH   = 11'b001_0000_0000,
        S_READTOP = 11'b010_0000_0000,
        S_FINISH  = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;
    state_t after;

    // Where a character's work ends
    assign after = stat.last ? S_FLUSH : S_IDLE;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.cls == CLS_DIGIT)
                begin
                    cmd.acc_digit = 1'b1;
                    state_next    = after;
                end
                else
                begin
                    cmd.push_acc = 1'b1;
                    state_next   = (stat.cls == CLS_SEMI) ? after : S_POP;
                end
            end
            S_POP:
            begin
                if (stat.lt2)
                begin
                    cmd.underflow = 1'b1;
                    state_next    = after;
                end
                else
                begin
                    cmd.pop    = 1'b1;
                    state_next = S_OPER;
                end
            end
            S_OPER:
            begin
                case (stat.cls)
                    CLS_ADD, CLS_SUB, CLS_MUL:
                    begin
                        cmd.oper   = 1'b1;
                        state_next = S_PUSHRES;
                    end
                    CLS_DIV:
                    begin
                        if (stat.b_zero)
                        begin
                            cmd.flag_divz = 1'b1;
                            state_next    = after;
                        end
                        else
                        begin
                            cmd.oper   = 1'b1;
                            state_next = S_DIV;
                        end
                    end
                    CLS_POW:
                    begin
                        if (stat.b_neg && stat.a_zero)
                        begin
                            cmd.flag_divz = 1'b1;
                            state_next    = after;
                        end
                        else
                        begin
                            cmd.oper   = 1'b1;
                            state_next = stat.b_neg ? S_PUSHRES : S_POW;
                        end
                    end
                    default: state_next = after;  // unknown: operands dropped
                endcase
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done)
                    state_next = S_DIVFIX;
            end
            S_DIVFIX:
            begin
                cmd.div_fix = 1'b1;
                state_next  = S_PUSHRES;
            end
            S_POW:
            begin
                cmd.pow_step = 1'b1;
                if (stat.pow_done)
                    state_next = S_PUSHRES;
            end
            S_PUSHRES:
            begin
                cmd.push_res = 1'b1;
                state_next   = after;
            end
            S_FLUSH:
            begin
                cmd.push_acc = 1'b1;
                state_next   = S_READTOP;
            end
            S_READTOP:
            begin
                cmd.rd_top = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign item_stall = (state_reg != S_IDLE);

endmodule

>>> rtl/postfix_expression_evaluator.sv
// Top level of the postfix expression evaluator: controller plus datapath.
// Each character is decoded in turn: digits build a number, an operator pops two operands
// and pushes its result; '/' and '^' run iterative loops, which a zero divisor or a negative
// exponent skips. The final character's result waits until the previous one is taken.
// One character is in work at a time; the divide and power loops set the worst case.
// Reset (rst_n low, asynchronous) empties the stack, clears number, error and result valid.
`include "postfix_expression_evaluator_defines.svh"

module postfix_expression_evaluator #(
    parameter int STACK_DEPTH = pee_pkg::STACK_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [7:0]  ch,
    input  logic        last,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [31:0] value,
    output logic [2:0]  status
);
    import pee_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    pee_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    pee_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ch           (ch),
        .last         (last),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .value        (value),
        .status       (status)
    );

    // Checks
    `PEE_ASSERT_IMPL(a_cmd_single, 1'b1, $onehot0(cmd), "more than one datapath command")
    `PEE_ASSERT_NEXT(a_busy_after, item_valid && !item_stall, item_stall, "took two items")
    `PEE_ASSERT_IMPL(a_err_zero, result_valid && status != ST_OK, value == '0, "error value")

endmodule

>>> sim/postfix_expression_evaluator_tb.sv
// Self-checking testbench for the postfix expression evaluator, with its own evaluation model.
`timescale 1ns / 1ps

module postfix_expression_evaluator_tb;

    import pee_pkg::*;

    localparam int DEPTH        = STACK_DEPTH_DEF;
    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int DRAIN_CYCLES = 100;   // longest operator (power) plus final-character cost
    localparam int HOLD_CYCLES  = 500;
    localparam int RANDOM_CHARS = 300;   // per idling phase
    localparam int MAX_REPORTS  = 100;

    typedef struct packed {
        logic [31:0] value;
        status_t     status;
    } eval_result_t;

    // DUT ports
    logic        clk = 1'b0;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    logic [7:0]  ch;
    logic        last;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [31:0] value;
    logic [2:0]  status;

    // Expression evaluation model state
    logic [31:0] model_stack [0:DEPTH-1];
    int          model_cnt = 0;
    logic [31:0] model_num = 32'd0;
    bit          model_in_num = 1'b0;
    status_t     model_err = ST_OK;

    eval_result_t expected_results [$];
    eval_result_t front_result;
    logic [7:0]   pending_chars [$];
    logic [7:0]   op_set [0:4] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET};

    // Traffic control
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    bit          hold_req = 1'b0;
    logic        hold_on = 1'b0;

    // Bookkeeping
    int cycle_count = 0;
    int error_count = 0;
    int chars_sent = 0;
    int exprs_sent = 0;
    int results_checked = 0;

    postfix_expression_evaluator u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .ch           (ch),
        .last         (last),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .value        (value),
        .status       (status)
    );

    // Clock
    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Cycle limit watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, expected_results.size());
            $display("postfix_expression_evaluator_tb: done, errors");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_count < MAX_REPORTS)
        begin
            $display("MISMATCH @%0t: %s got 0x%08h want 0x%08h", $realtime, what, got, want);
        end
        error_count++;
    endtask

    // ---------------------------------------------------------------
    // Evaluation model
    // ---------------------------------------------------------------

    function automatic bit is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // Only the first error of an expression is kept
    function automatic void raise_err(input status_t s);
        if (model_err == ST_OK)
        begin
            model_err = s;
        end
    endfunction

    function automatic void push_word(input logic [31:0] v);
        if (model_cnt >= DEPTH)
        begin
            raise_err(ST_OVER);
        end
        else
        begin
            model_stack[model_cnt] = v;
            model_cnt++;
        end
    endfunction

    // Signed divide truncating toward zero; 0 on a zero divisor
    function automatic bit div_trunc(input logic [31:0] a, input logic [31:0] b,
                                     output logic [31:0] q);
        logic [31:0] ua;
        logic [31:0] ub;
        logic [31:0] mag;
        q = 32'd0;
        if (b == 32'd0)
        begin
            return 1'b0;
        end
        ua  = a[31] ? -a : a;
        ub  = b[31] ? -b : b;
        mag = ua / ub;
        q   = (a[31] != b[31]) ? -mag : mag;
        return 1'b1;
    endfunction

    // Wrapped integer power; a negative exponent truncates like integer division
    function automatic bit pow_wrap(input logic [31:0] base, input logic [31:0] ex,
                                    output logic [31:0] r);
        logic [31:0] acc;
        logic [31:0] sq;
        r = 32'd0;
        if (ex[31])
        begin
            if (base == 32'd1)
            begin
                r = 32'd1;
            end
            else if (base == 32'hFFFF_FFFF)
            begin
                r = ex[0] ? 32'hFFFF_FFFF : 32'd1;
            end
            else if (base == 32'd0)
            begin
                return 1'b0;
            end
            return 1'b1;
        end
        acc = 32'd1;
        sq  = base;
        for (int i = 0; i < 31; i++)
        begin
            if (ex[i])
            begin
                acc = acc * sq;
            end
            sq = sq * sq;
        end
        r = acc;
        return 1'b1;
    endfunction

    // Pop two operands and apply one operator; unknown characters just drop them
    function automatic void apply_op(input logic [7:0] c);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] r;
        bit          ok;
        if (model_cnt < 2)
        begin
            model_cnt = 0;
            raise_err(ST_UNDER);
            return;
        end
        b = model_stack[model_cnt-1];
        a = model_stack[model_cnt-2];
        model_cnt -= 2;
        ok = 1'b1;
        r  = 32'd0;
        case (c)
            CH_PLUS:  r = a + b;
            CH_MINUS: r = a - b;
            CH_STAR:  r = a * b;
            CH_SLASH: ok = div_trunc(a, b, r);
            CH_CARET: ok = pow_wrap(a, b, r);
            default:  return;
        endcase
        if (!ok)
        begin
            raise_err(ST_DIVZ);
        end
        else
        begin
            push_word(r);
        end
    endfunction

    // One accepted character; the final one queues the expected result
    function automatic void eval_char(input logic [7:0] c, input logic fin);
        eval_result_t r;
        if (is_digit(c))
        begin
            model_num    = model_num * 32'd10 + 32'(c - CH_ZERO);
            model_in_num = 1'b1;
        end
        else
        begin
            if (model_in_num)
            begin
                push_word(model_num);
                model_num    = 32'd0;
                model_in_num = 1'b0;
            end
            if (c != CH_SEMI)
            begin
                apply_op(c);
            end
        end
        if (fin)
        begin
            if (model_in_num)
            begin
                push_word(model_num);
            end
            r.value = 32'd0;
            if (model_err != ST_OK)
            begin
                r.status = model_err;
            end
            else if (model_cnt == 0)
            begin
                r.status = ST_EMPTY;
            end
            else
            begin
                r.value  = model_stack[model_cnt-1];
                r.status = ST_OK;
            end
            expected_results.push_back(r);
            model_cnt    = 0;
            model_num    = 32'd0;
            model_in_num = 1'b0;
            model_err    = ST_OK;
        end
    endfunction

    // ---------------------------------------------------------------
    // Result side: random stall, long hold-off, compare
    // ---------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("result with nothing pending, value", value, 32'd0);
            end
            else
            begin
                front_result = expected_results.pop_front();
                if (value !== front_result.value)
                begin
                    report_mismatch("value", value, front_result.value);
                end
                if (status !== front_result.status)
                begin
                    report_mismatch("status", 32'(status), 32'(front_result.status));
                end
                results_checked++;
            end
        end
        result_stall <= hold_on || ($urandom_range(0, 99) < rx_idle_pct);
    end

    // Long receiver hold-off, counted here once requested
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_on <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_on <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Input side
    // ---------------------------------------------------------------

    // Offer one character and wait for its transfer; valid stays up afterwards
    task automatic send_char(input logic [7:0] c, input logic fin);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        ch         <= c;
        last       <= fin;
        @(posedge clk);
        while (item_stall)
        begin
            @(posedge clk);
        end
        eval_char(c, fin);
        chars_sent++;
    endtask

    // Send the queued expression, flagging its final character
    task automatic send_pending();
        for (int i = 0; i < pending_chars.size(); i++)
        begin
            send_char(pending_chars[i], i == pending_chars.size() - 1);
        end
        exprs_sent++;
    endtask

    task automatic send_text(input string s);
        pending_chars.delete();
        for (int i = 0; i < s.len(); i++)
        begin
            pending_chars.push_back(s[i]);
        end
        send_pending();
    endtask

    // Drop valid, wait for every pending result, then let the block settle
    task automatic wait_drained();
        item_valid <= 1'b0;
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ---------------------------------------------------------------
    // Expression generators
    // ---------------------------------------------------------------

    // Number token: mostly short, sometimes long enough to wrap
    function automatic void append_number();
        int len;
        if (pending_chars.size() != 0 && is_digit(pending_chars[$]))
        begin
            pending_chars.push_back(CH_SEMI);
        end
        len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(4, 10);
        repeat (len) pending_chars.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    endfunction

    // Operator token; returns how many entries it takes off the stack in net
    function automatic int append_op();
        logic [7:0] c;
        if ($urandom_range(0, 1) == 0)
        begin
            pending_chars.push_back(CH_SEMI);
        end
        if ($urandom_range(0, 19) == 0)
        begin
            do
            begin
                c = 8'($urandom_range(0, 255));
            end
            while (is_digit(c) || c == CH_SEMI || c == CH_PLUS || c == CH_MINUS ||
                   c == CH_STAR || c == CH_SLASH || c == CH_CARET);
            pending_chars.push_back(c);
            return 2;
        end
        pending_chars.push_back(op_set[$urandom_range(0, 4)]);
        return 1;
    endfunction

    // Well-formed expression with random numbers and operators
    function automatic void make_wellformed();
        int depth;
        int numbers_left;
        pending_chars.delete();
        depth        = 0;
        numbers_left = $urandom_range(1, 9);
        while (numbers_left > 0 || depth > 1)
        begin
            if (numbers_left > 0 && (depth < 2 || $urandom_range(0, 1) == 1))
            begin
                append_number();
                depth++;
                numbers_left--;
            end
            else
            begin
                depth -= append_op();
            end
        end
        if ($urandom_range(0, 7) == 0)
        begin
            pending_chars.push_back(CH_SEMI);
        end
    endfunction

    // Arbitrary bytes
    function automatic void make_noise();
        pending_chars.delete();
        repeat ($urandom_range(1, 8)) pending_chars.push_back(8'($urandom_range(0, 255)));
    endfunction

    // Broken sequences: random token soup, or deep stacks that may overflow
    function automatic void make_broken();
        pending_chars.delete();
        if ($urandom_range(0, 2) == 0)
        begin
            repeat ($urandom_range(14, 20))
            begin
                pending_chars.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                pending_chars.push_back(CH_SEMI);
            end
            repeat ($urandom_range(0, 4)) void'(append_op());
        end
        else
        begin
            repeat ($urandom_range(1, 8))
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    append_number();
                end
                else
                begin
                    void'(append_op());
                end
            end
        end
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Number building, empty stack, extremes of the accumulator
    task automatic test_numbers();
        send_text("7");
        send_text(";");
        send_text("4294967295");
        send_text("9999999999");
        send_text("1;2;3");
        wait_drained();
    endtask

    // Each operator, truncating division and the signed wrap of MIN / -1
    task automatic test_operators();
        send_text("3;4+");
        send_text("3;4-");
        send_text("6;7*");
        send_text("0;7-2/");
        send_text("2147483648;0;1-/");
        send_text("2;10^");
        send_text("3;40^");
        send_text("0;0^");
        wait_drained();
    endtask

    // Negative exponents: base 1, base -1 by parity, base 0, any other base
    task automatic test_negative_powers();
        send_text("1;0;3-^");
        send_text("0;1-;0;3-^");
        send_text("0;1-;0;2-^");
        send_text("0;0;1-^");
        send_text("5;0;1-^");
        wait_drained();
    endtask

    // Divide by zero, underflow, overflow, unknown characters, first error kept
    task automatic test_errors();
        string deep;
        deep = "";
        send_text("5;0/");
        send_text("5+");
        send_text("5;0/+");
        repeat (17) deep = {deep, "1;"};
        send_text({deep, "+"});
        send_text("3;4@");
        pending_chars.delete();
        send_text("3;4;5");
        send_char(8'hFF, 1'b1);
        send_char(8'h00, 1'b1);
        exprs_sent += 2;
        wait_drained();
    endtask

    // Mostly well-formed random expressions, the rest noise and broken ones
    task automatic test_random_traffic(input int unsigned tx_pct, input int unsigned rx_pct);
        int start;
        int pick;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        start = chars_sent;
        while (chars_sent - start < RANDOM_CHARS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                make_wellformed();
            end
            else if (pick < 85)
            begin
                make_noise();
            end
            else
            begin
                make_broken();
            end
            send_pending();
        end
        wait_drained();
    endtask

    // Receiver holds off while short expressions keep coming, so the input backs up
    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req    = 1'b1;
        repeat (60)
        begin
            pending_chars.delete();
            append_number();
            append_number();
            void'(append_op());
            send_pending();
        end
        wait_drained();
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------

    initial
    begin
        rst_n      = 1'b0;
        item_valid = 1'b0;
        ch         = 8'd0;
        last       = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_numbers();
        test_operators();
        test_negative_powers();
        test_errors();
        test_random_traffic(21, 81);
        test_random_traffic(81, 21);
        test_random_traffic(0, 0);
        test_backpressure();

        if (expected_results.size() != 0)
        begin
            report_mismatch("results never delivered, count", 32'(expected_results.size()), 0);
        end
        $display("covered %0d characters in %0d expressions: all operators, error cases,",
                 chars_sent, exprs_sent);
        $display("random and noisy input, idling, a long receiver hold-off; %0d results checked",
                 results_checked);
        if (error_count == 0)
        begin
            $display("postfix_expression_evaluator_tb: done, clean");
        end
        else
        begin
            $display("postfix_expression_evaluator_tb: done, errors");
        end
        $finish;
    end

endmodule
